// File: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away when SYNTH is set.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion that is held off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/xsf_pkg.sv
// -----------------------------------------------------------------------------
// XOR sprite framebuffer package
// Shared payload types, mode codes, controller commands and size defaults.
// -----------------------------------------------------------------------------
package xsf_pkg;

    // Default screen geometry and the fixed sprite width.
    localparam int SCREEN_W_DEF = 64;
    localparam int SCREEN_H_DEF = 32;
    localparam int SPRITE_W     = 8;

    // Field widths of the channels.
    localparam int MODE_BITS = 2;
    localparam int COORD_BITS = 8;
    localparam int RIDX_BITS = 4;
    localparam int ROW_OUT_BITS = 64;

    // Operation codes; the unused code behaves as a read.
    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DRAW  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd2;

    // One command item.
    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [RIDX_BITS-1:0]  row_index;
        logic [SPRITE_W-1:0]   row_bits;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic                    collision;
        logic [ROW_OUT_BITS-1:0] screen_row;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming command
        logic rd;     // compute the row address and read the store
        logic upd;    // modify, write back and load the result register
    } t_ctl;

endpackage

// File: rtl/xsf_stream_if.sv
// -----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload per transfer; a transfer completes when valid and
// ready are both high at a rising clock edge.
// -----------------------------------------------------------------------------
interface xsf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/xsf_ctrl.sv
// -----------------------------------------------------------------------------
// XOR sprite framebuffer controller
// Sequences capture, store read and update for one command at a time and
// owns the result valid flag.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module xsf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output xsf_pkg::t_ctl o_ctl
);
    import xsf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   upd_go;

    // The update step waits while a previous result has not been taken.
    assign upd_go = (r_state == S_UPD) && (!r_out_valid || i_out_ready);

    // Commands to the datapath.
    always_comb begin
        o_ctl.load = (r_state == S_IDLE) && i_in_valid;
        o_ctl.rd   = (r_state == S_RD);
        o_ctl.upd  = upd_go;
    end

    // Next state and result valid flag.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // An accepted command always goes on to the read step.
    `ASSERT_CLK(a_load_then_rd, i_clk, i_rst_n, o_ctl.load |=> o_ctl.rd, "load not followed by read")
    // A result only disappears once the sink has taken it.
    `ASSERT_CLK(a_out_held, i_clk, i_rst_n, $fell(r_out_valid) |-> $past(i_out_ready), "result dropped before transfer")
    // A new result only appears after an update step.
    `ASSERT_CLK(a_out_from_upd, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(o_ctl.upd), "result without update")
    // At most one command step is active in any cycle.
    `ASSERT_CLK(a_one_step, i_clk, i_rst_n, $onehot0({o_ctl.load, o_ctl.rd, o_ctl.upd}), "overlapping command steps")

endmodule

// File: rtl/xsf_datapath.sv
// -----------------------------------------------------------------------------
// XOR sprite framebuffer datapath
// Holds the frame store, the row valid bits and the collision flag, builds
// the sprite mask and performs the read-modify-write of one row.
// -----------------------------------------------------------------------------
module xsf_datapath #(
    parameter int SCREEN_W = xsf_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = xsf_pkg::SCREEN_H_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  xsf_pkg::t_ctl i_ctl,
    input  xsf_pkg::t_cmd i_cmd,
    output xsf_pkg::t_rsp o_rsp
);
    import xsf_pkg::*;

    localparam int XW = $clog2(SCREEN_W);
    localparam int YW = $clog2(SCREEN_H);

    typedef logic [XW-1:0] t_xtab [256];
    typedef logic [YW-1:0] t_ytab [256];
    typedef logic [YW-1:0] t_rtab [16];

    // Modulo tables, built at elaboration.
    function automatic t_xtab build_xtab();
        t_xtab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = XW'(i % SCREEN_W);
        end
        return tab;
    endfunction

    function automatic t_ytab build_ytab();
        t_ytab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = YW'(i % SCREEN_H);
        end
        return tab;
    endfunction

    function automatic t_rtab build_rtab();
        t_rtab tab;
        for (int i = 0; i < 16; i++) begin
            tab[i] = YW'(i % SCREEN_H);
        end
        return tab;
    endfunction

    localparam t_xtab XTAB = build_xtab();
    localparam t_ytab YTAB = build_ytab();
    localparam t_rtab RTAB = build_rtab();

    // Frame store and per-row valid bits; an invalid row reads as zero.
    logic [SCREEN_W-1:0] mem [SCREEN_H];
    logic [SCREEN_H-1:0] r_valid;

    t_cmd                r_cmd;
    logic [YW-1:0]       r_row;
    logic [SCREEN_W-1:0] r_sprite;
    logic [SCREEN_W-1:0] r_rd;
    logic                r_hit;
    logic                r_out_collision;
    logic [SCREEN_W-1:0] r_out_row;

    logic [YW:0]         ysum;
    logic [YW-1:0]       n_row;
    logic [SCREEN_W-1:0] n_sprite;
    logic [SCREEN_W-1:0] old_row;
    logic [SCREEN_W-1:0] xor_row;
    logic                n_hit;
    logic [SCREEN_W-1:0] n_out_row;

    // Capture the command on transfer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
        end
    end

    // Target row: for a draw, origin row plus sprite row, wrapped to the screen height; otherwise the origin row.
    always_comb begin
        ysum = {1'b0, YTAB[r_cmd.start_y]} + {1'b0, RTAB[r_cmd.row_index]};
        if (ysum >= (YW+1)'(SCREEN_H)) begin
            ysum = ysum - (YW+1)'(SCREEN_H);
        end
        if (r_cmd.mode == MODE_DRAW) begin
            n_row = ysum[YW-1:0];
        end else begin
            n_row = YTAB[r_cmd.start_y];
        end
    end

    // Sprite mask: bit 7 lands on the origin column, later bits wrap right.
    always_comb begin
        logic [XW:0] csum;
        n_sprite = '0;
        for (int w = 0; w < SPRITE_W; w++) begin
            csum = {1'b0, XTAB[r_cmd.start_x]} + (XW+1)'(w);
            if (csum >= (XW+1)'(SCREEN_W)) begin
                csum = csum - (XW+1)'(SCREEN_W);
            end
            if (r_cmd.row_bits[SPRITE_W-1-w]) begin
                n_sprite[csum[XW-1:0]] = 1'b1;
            end
        end
    end

    // Read step: register address, mask and store data.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_row    <= n_row;
            r_sprite <= n_sprite;
            r_rd     <= mem[n_row];
        end
    end

    // Update step: XOR the sprite in on a draw and decide the result.
    always_comb begin
        old_row   = r_valid[r_row] ? r_rd : '0;
        xor_row   = old_row ^ r_sprite;
        n_hit     = r_hit;
        n_out_row = old_row;
        case (r_cmd.mode)
            MODE_CLEAR: begin
                n_out_row = '0;
            end
            MODE_DRAW: begin
                if (r_cmd.row_index == '0) begin
                    n_hit = 1'b0;
                end
                if ((old_row & r_sprite) != '0) begin
                    n_hit = 1'b1;
                end
                n_out_row = xor_row;
            end
            default: begin
                n_out_row = old_row;
            end
        endcase
    end

    // Store write-back.
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && (r_cmd.mode == MODE_DRAW)) begin
            mem[r_row] <= xor_row;
        end
    end

    // Row valid bits and collision flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else if (i_ctl.upd) begin
            r_hit <= n_hit;
            if (r_cmd.mode == MODE_CLEAR) begin
                r_valid <= '0;
            end else if (r_cmd.mode == MODE_DRAW) begin
                r_valid[r_row] <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_out_collision <= n_hit;
            r_out_row       <= n_out_row;
        end
    end

    assign o_rsp.collision  = r_out_collision;
    assign o_rsp.screen_row = ROW_OUT_BITS'(r_out_row);

endmodule

// File: rtl/xor_sprite_framebuffer_top.sv
// -----------------------------------------------------------------------------
// XOR sprite framebuffer top level
// Monochrome framebuffer with clear, XOR sprite-row draw with collision and
// whole-row read.
//
//   Channel  Dir  Payload                                          Role
//   i_cmd    in   mode, start_x, start_y, row_index, row_bits     command
//   o_rsp    out  collision, screen_row                            result
//
// Each command passes through capture, store read (registered read port),
// then update and write-back; the next command is accepted in the cycle after
// the update. Reset clears the row valid bits and the collision flag, so the
// screen reads as blank at once. The result sits in an output register; a new
// command is taken while it waits and only its update step stalls until the
// previous result has been transferred.
// -----------------------------------------------------------------------------
module xor_sprite_framebuffer_top #(
    parameter int SCREEN_W = xsf_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = xsf_pkg::SCREEN_H_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xsf_stream_if.sink    i_cmd,
    xsf_stream_if.source  o_rsp
);
    import xsf_pkg::*;

    t_ctl ctl;
    logic in_ready;
    logic out_valid;
    t_rsp rsp;

    // Sequencing.
    xsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_ctl       (ctl)
    );

    // Store and arithmetic.
    xsf_datapath #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cmd   (i_cmd.data),
        .o_rsp   (rsp)
    );

    assign i_cmd.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp;

endmodule

// File: bench/tb_xor_sprite_framebuffer_top.sv
// -----------------------------------------------------------------------------
// XOR sprite framebuffer testbench
// Sends clear, sprite-row draw and row read commands through the command
// stream. A behavioral copy of the framebuffer and collision flag computes the
// response of every command that transfers, and each response that transfers
// is compared with the oldest prediction. Both streams idle at random in
// phases, and the response side holds off once so that the block backs up.
// -----------------------------------------------------------------------------
module tb_xor_sprite_framebuffer_top;
    import xsf_pkg::*;

    localparam int SCREEN_W = SCREEN_W_DEF;
    localparam int SCREEN_H = SCREEN_H_DEF;

    // The fourth mode code has no name in the package; it behaves as a read.
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

    localparam logic [ROW_OUT_BITS-1:0] ROW_MASK =
        {ROW_OUT_BITS{1'b1}} >> (ROW_OUT_BITS - SCREEN_W);

    localparam int NUM_CMDS      = 1375;
    localparam int STALL_LIMIT   = 3000;
    localparam int BACKUP_CYCLES = 400;
    localparam int DRAIN_CYCLES  = 16;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xsf_stream_if #(.T(t_cmd)) cmd_if ();
    xsf_stream_if #(.T(t_rsp)) rsp_if ();

    xor_sprite_framebuffer_top #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Clock with a period of 12 time units.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow framebuffer state.
    logic [ROW_OUT_BITS-1:0] pixel_rows [SCREEN_H];
    logic                    hit_latched;

    t_cmd        pending_cmds [$];
    t_rsp        expected_rsps [$];
    int unsigned total_cmds;
    int unsigned cmds_sent;
    int unsigned failures;
    int unsigned stall_cycles;
    int unsigned backup_left;
    bit          backup_done;

    // Applies one command to the shadow framebuffer and returns its response.
    function automatic t_rsp apply_fb_command(t_cmd c);
        t_rsp                    res;
        logic [ROW_OUT_BITS-1:0] sprite_mask;
        int unsigned             row_sel;
        int unsigned             col;
        sprite_mask = '0;
        case (c.mode)
            MODE_CLEAR: begin
                foreach (pixel_rows[r]) pixel_rows[r] = '0;
                row_sel = int'(c.start_y) % SCREEN_H;
            end
            MODE_DRAW: begin
                row_sel = (int'(c.start_y) + int'(c.row_index)) % SCREEN_H;
                // Bit 7 of the byte lands on the origin column, wrapping right.
                for (int w = 0; w < SPRITE_W; w++) begin
                    if (c.row_bits[SPRITE_W-1-w]) begin
                        col = (int'(c.start_x) + w) % SCREEN_W;
                        sprite_mask[col] = 1'b1;
                    end
                end
                if (c.row_index == '0) hit_latched = 1'b0;
                if ((pixel_rows[row_sel] & sprite_mask) != '0) hit_latched = 1'b1;
                pixel_rows[row_sel] = (pixel_rows[row_sel] ^ sprite_mask) & ROW_MASK;
            end
            default: begin
                row_sel = int'(c.start_y) % SCREEN_H;
            end
        endcase
        res.collision  = hit_latched;
        res.screen_row = pixel_rows[row_sel] & ROW_MASK;
        return res;
    endfunction

    // The run has three traffic phases by the number of commands sent.
    function automatic int traffic_phase();
        if (cmds_sent < total_cmds / 3) return 0;
        if (cmds_sent < (2 * total_cmds) / 3) return 1;
        return 2;
    endfunction

    function automatic int sender_idle_pct();
        case (traffic_phase())
            0:       return 7;
            1:       return 82;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (traffic_phase())
            0:       return 82;
            1:       return 7;
            default: return 0;
        endcase
    endfunction

    task automatic queue_cmd(logic [MODE_BITS-1:0] mode, logic [COORD_BITS-1:0] sx,
                             logic [COORD_BITS-1:0] sy, logic [RIDX_BITS-1:0] ri,
                             logic [SPRITE_W-1:0] bits);
        t_cmd c;
        c.mode      = mode;
        c.start_x   = sx;
        c.start_y   = sy;
        c.row_index = ri;
        c.row_bits  = bits;
        pending_cmds.push_back(c);
    endtask

    // Command driver: offers queued commands and predicts each transfer.
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            busy = cmd_if.valid;
            if (cmd_if.valid && cmd_if.ready) begin
                expected_rsps.push_back(apply_fb_command(cmd_if.data));
                cmds_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    cmd_if.data  <= pending_cmds.pop_front();
                    cmd_if.valid <= 1'b1;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each transfer and drives ready.
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response: collision %0d, screen_row %h",
                           rsp_if.data.collision, rsp_if.data.screen_row);
                    failures++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (rsp_if.data.collision !== exp_rsp.collision) begin
                        $error("collision: expected %0d, actual %0d",
                               exp_rsp.collision, rsp_if.data.collision);
                        failures++;
                    end
                    if (rsp_if.data.screen_row !== exp_rsp.screen_row) begin
                        $error("screen_row: expected %h, actual %h",
                               exp_rsp.screen_row, rsp_if.data.screen_row);
                        failures++;
                    end
                end
            end
            // One long hold-off in the last phase lets commands pile up.
            if (!backup_done && traffic_phase() == 2) begin
                backup_left = BACKUP_CYCLES;
                backup_done = 1'b1;
            end
            if (backup_left != 0) begin
                backup_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [SPRITE_W-1:0]   sprite_rows [16];
        int unsigned           n_rows;
        int unsigned           pick;
        bit                    have_sprite;

        i_rst_n      = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        rsp_if.ready = 1'b0;
        hit_latched  = 1'b0;
        foreach (pixel_rows[r]) pixel_rows[r] = '0;
        cmds_sent    = 0;
        failures     = 0;
        stall_cycles = 0;
        backup_left  = 0;
        backup_done  = 1'b0;
        have_sprite  = 1'b0;

        // Blank screen after reset, then a hit and a carried flag.
        queue_cmd(MODE_READ, 8'd0, 8'd0, 4'd0, 8'h00);
        queue_cmd(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF);
        queue_cmd(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'h81);
        queue_cmd(MODE_DRAW, 8'd0, 8'd0, 4'd1, 8'h00);
        // Column wrap at the right edge and origins beyond the screen.
        queue_cmd(MODE_DRAW, 8'd60, 8'd31, 4'd0, 8'hAA);
        queue_cmd(MODE_DRAW, 8'd255, 8'd255, 4'd15, 8'hFF);
        queue_cmd(MODE_READ, 8'd255, 8'd255, 4'd15, 8'hFF);
        queue_cmd(MODE_SPARE, 8'd0, 8'd14, 4'd15, 8'h00);
        queue_cmd(MODE_DRAW, 8'd56, 8'd0, 4'd0, 8'h01);
        queue_cmd(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'h00);
        // Clear keeps the flag; a later row 0 restarts it.
        queue_cmd(MODE_DRAW, 8'd56, 8'd0, 4'd2, 8'hFF);
        queue_cmd(MODE_CLEAR, 8'd255, 8'd200, 4'd15, 8'hFF);
        queue_cmd(MODE_READ, 8'd0, 8'd14, 4'd0, 8'h00);
        queue_cmd(MODE_SPARE, 8'd255, 8'd31, 4'd7, 8'h5A);
        queue_cmd(MODE_DRAW, 8'd0, 8'd0, 4'd15, 8'hFF);
        queue_cmd(MODE_DRAW, 8'd0, 8'd15, 4'd0, 8'hF0);
        queue_cmd(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'h00);
        // Sprite across both edges, drawn then erased.
        for (int k = 0; k < 2; k++) begin
            queue_cmd(MODE_DRAW, 8'd62, 8'd30, 4'd0, 8'hC3);
            queue_cmd(MODE_DRAW, 8'd62, 8'd30, 4'd1, 8'h3C);
            queue_cmd(MODE_DRAW, 8'd62, 8'd30, 4'd2, 8'h99);
            queue_cmd(MODE_DRAW, 8'd62, 8'd30, 4'd3, 8'h66);
        end

        // Mostly whole sprites, often redrawn in place to erase them.
        while (pending_cmds.size() < NUM_CMDS) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                if (!have_sprite || $urandom_range(99) >= 30) begin
                    if ($urandom_range(1) == 0) begin
                        sx = 8'($urandom_range(255));
                        sy = 8'($urandom_range(255));
                    end else begin
                        sx = 8'($urandom_range(3) * 8);
                        sy = 8'($urandom_range(3) * 4);
                    end
                    n_rows = $urandom_range(1, 16);
                    foreach (sprite_rows[r]) sprite_rows[r] = 8'($urandom_range(255));
                    have_sprite = 1'b1;
                end
                for (int r = 0; r < n_rows; r++) begin
                    queue_cmd(MODE_DRAW, sx, sy, 4'(r), sprite_rows[r]);
                end
            end else if (pick < 85) begin
                queue_cmd(($urandom_range(3) == 0) ? MODE_SPARE : MODE_READ,
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          4'($urandom_range(15)), 8'($urandom_range(255)));
            end else if (pick < 98) begin
                queue_cmd(MODE_DRAW, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          4'($urandom_range(15)), 8'($urandom_range(255)));
            end else begin
                queue_cmd(MODE_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          4'($urandom_range(15)), 8'($urandom_range(255)));
            end
        end
        total_cmds = pending_cmds.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_sent < total_cmds) @(posedge i_clk);
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0 && expected_rsps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/xsf_pkg.sv
rtl/xsf_stream_if.sv
rtl/xsf_ctrl.sv
rtl/xsf_datapath.sv
rtl/xor_sprite_framebuffer_top.sv
bench/tb_xor_sprite_framebuffer_top.sv
